// File: rtl/utcmjd_pkg.sv
// Package: beat types, constants and month tables for the UTC to MJD converter.
`timescale 1ns / 1ps

package utcmjd_pkg;

  // Input beat: one UTC timestamp
  typedef struct packed {
    logic [13:0] year;
    logic [8:0]  day_of_year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } utcmjd_in_t;

  // Output beat: day number, seconds of day, date check
  typedef struct packed {
    logic signed [22:0] mjd_day;
    logic [16:0]        seconds_of_day;
    logic               date_valid;
  } utcmjd_out_t;

  localparam int unsigned MONTHS = 12;

  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [14:0] DAY_BIAS_A   = 15'd4711;    // 4712 less one for Jan/Feb
  localparam logic [25:0] DAYS_PER_4Y  = 26'd1461;
  localparam logic [14:0] CENT_BIAS    = 15'd4899;    // 4900 less one for Jan/Feb
  localparam logic [27:0] DIV100_RECIP = 28'd5243;    // ceil(2^19 / 100)
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [24:0] MJD_OFFSET   = 25'd2399904;

  // Quotient by 100 through reciprocal multiply; exact for x below 25600 (8-bit result)
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [27:0] prod;
    prod = 28'(x) * DIV100_RECIP;
    return prod[DIV100_SHIFT +: 8];
  endfunction

  // Days before the first of each month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Days from March 1 to the first of the month, (306*((m+9)%12)+5)/10
  function automatic logic [8:0] march_offset(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/utcmjd_calc.sv
// Datapath: one timestamp to Modified Julian Day and seconds of day.
`timescale 1ns / 1ps

module utcmjd_calc (
  input  utcmjd_pkg::utcmjd_in_t  in_i,
  output utcmjd_pkg::utcmjd_out_t out_o
);
  import utcmjd_pkg::*;

  logic [7:0]  year_cent;
  logic        cent_year;
  logic        leap;
  logic [8:0]  year_len;
  logic        valid;
  logic [3:0]  month;
  logic        early;          // January or February
  logic [8:0]  month_start;
  logic [8:0]  day;
  logic [14:0] year_a;
  logic [25:0] span_early;
  logic [25:0] span_sel;
  logic [23:0] a_term;
  logic [14:0] year_c;
  logic [7:0]  cent_early;
  logic [7:0]  cent_late;
  logic [7:0]  cent_sel;
  logic [9:0]  cent_x3;
  logic [7:0]  c_term;
  logic [24:0] mjd_sum;

  // Gregorian leap rule: by 4, not by 100 unless by 400
  assign year_cent = div100(15'(in_i.year));
  assign cent_year = (14'(year_cent) * 14'd100) == in_i.year;
  assign leap      = (in_i.year[1:0] == 2'b00) && (!cent_year || (year_cent[1:0] == 2'b00));
  assign year_len  = 9'd365 + 9'(leap);

  assign valid = (in_i.year != 14'd0) && (in_i.year <= YEAR_MAX) &&
                 (in_i.day_of_year != 9'd0) && (in_i.day_of_year <= year_len);

  // Find the month: last month whose start lies before the day
  always_comb begin
    month = 4'd1;
    for (int m = 2; m <= MONTHS; m++) begin
      if (in_i.day_of_year > days_before(4'(m)) + ((m >= 3) ? 9'(leap) : 9'd0)) begin
        month = 4'(m);
      end
    end
  end

  assign early       = (month < 4'd3);
  assign month_start = days_before(month) + (early ? 9'd0 : 9'(leap));
  assign day         = in_i.day_of_year - month_start;

  // Four-year day term, both shifted years in parallel
  assign year_a     = 15'(in_i.year) + DAY_BIAS_A;
  assign span_early = 26'(year_a) * DAYS_PER_4Y;
  assign span_sel   = early ? span_early : span_early + DAYS_PER_4Y;
  assign a_term     = span_sel[25:2];

  // Century correction, both shifted years in parallel
  assign year_c     = 15'(in_i.year) + CENT_BIAS;
  assign cent_early = div100(year_c);
  assign cent_late  = div100(year_c + 15'd1);
  assign cent_sel   = early ? cent_early : cent_late;
  assign cent_x3    = 10'(cent_sel) * 10'd3;
  assign c_term     = cent_x3[9:2];

  // Combine; low 23 bits carry the two's complement result
  assign mjd_sum = 25'(a_term) + 25'(march_offset(month)) + 25'(day)
                 - 25'(c_term) - MJD_OFFSET;

  assign out_o.mjd_day        = valid ? $signed(mjd_sum[22:0]) : 23'sd0;
  assign out_o.seconds_of_day = 17'(in_i.hour) * 17'd3600 + 17'(in_i.minute) * 17'd60
                              + 17'(in_i.second);
  assign out_o.date_valid     = valid;

endmodule

// File: rtl/utc_to_modified_julian_day.sv
// Top level: UTC timestamp to Modified Julian Day with valid/ready channels.
`timescale 1ns / 1ps

// Converts one UTC timestamp (year, day of year, hour, minute, second) per beat
// into its Modified Julian Day number, seconds since midnight and a flag that
// says whether the day of year lies within the year (year 1 to 9999); when the
// flag is low the day number is zero while seconds_of_day is still given.
// The block takes one beat every clock cycle while the output side keeps up: an
// accepted beat lands in an input register, goes through a single combinational
// conversion stage and is caught in the result register once that register is
// free or being drained. The input side only stalls while both registers hold
// beats that the output side has not yet taken.
module utc_to_modified_julian_day (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  utcmjd_pkg::utcmjd_in_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output utcmjd_pkg::utcmjd_out_t out_data_o
);
  import utcmjd_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  utcmjd_in_t  s1_data_q;
  logic        out_valid_q, out_valid_d;
  utcmjd_out_t out_data_q;
  utcmjd_out_t calc_res;
  logic        out_free;
  logic        s1_move;
  logic        in_fire;

  // Advance when the result register is empty or being drained
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_move);
  assign out_valid_d = s1_move || (out_valid_q && !out_ready_i);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
  end

  utcmjd_calc u_calc (
    .in_i  (s1_data_q),
    .out_o (calc_res)
  );

  // Capture the result beat
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= calc_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Never stall the input while the output side can take a beat
  a_no_needless_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_free |-> in_ready_o)
    else $error("input stalled while result register free");

  // A held input beat keeps its payload while the output is blocked
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_data_q)))
    else $error("input register changed under stall");

  // A beat leaving the input register shows up as a result
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("beat lost between stages");

  // An invalid date carries a zero day number
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.date_valid) |-> (out_data_o.mjd_day == 23'sd0))
    else $error("invalid date with nonzero day number");

endmodule

// File: test/tb_top.sv
// Testbench for the UTC to Modified Julian Day converter: directed table, random beats, scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import utcmjd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned BEATS_PER_PHASE = 350;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam longint      JD_OF_MJD_ZERO = 2399904;
  localparam int unsigned LAST_YEAR    = 9999;

  // Days before the first of each month in a common year, months 1..12
  localparam int unsigned MONTH_START_DAY [0:12] =
    '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // One directed row: timestamp, and the result where it is obvious
  typedef struct packed {
    logic [13:0]        year;
    logic [8:0]         doy;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic               typed;
    logic signed [22:0] mjd_day;
    logic [16:0]        secs;
    logic               ok;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 25;
  localparam dir_row_t DIRECTED_ROWS [0:DIR_ROWS-1] = '{
    // MJD zero and J2000 with a leap second
    '{14'd1858, 9'd321, 5'd0, 6'd0, 6'd0, 1'b1, 23'sd0, 17'd0, 1'b1},
    '{14'd2000, 9'd1, 5'd23, 6'd59, 6'd60, 1'b1, 23'sd51544, 17'd86400, 1'b1},
    // years outside 1..9999
    '{14'd0, 9'd1, 5'd0, 6'd0, 6'd0, 1'b1, 23'sd0, 17'd0, 1'b0},
    '{14'd10000, 9'd100, 5'd12, 6'd0, 6'd0, 1'b1, 23'sd0, 17'd43200, 1'b0},
    '{14'd16383, 9'd511, 5'd31, 6'd63, 6'd63, 1'b1, 23'sd0, 17'd115443, 1'b0},
    // day zero and days past the end of the year
    '{14'd2023, 9'd0, 5'd1, 6'd1, 6'd1, 1'b1, 23'sd0, 17'd3661, 1'b0},
    '{14'd2023, 9'd366, 5'd0, 6'd0, 6'd0, 1'b1, 23'sd0, 17'd0, 1'b0},
    '{14'd1900, 9'd366, 5'd0, 6'd0, 6'd0, 1'b1, 23'sd0, 17'd0, 1'b0},
    '{14'd9999, 9'd366, 5'd0, 6'd0, 6'd0, 1'b1, 23'sd0, 17'd0, 1'b0},
    '{14'd2023, 9'd511, 5'd0, 6'd0, 6'd0, 1'b1, 23'sd0, 17'd0, 1'b0},
    // leap days, range ends, month boundaries
    '{14'd2024, 9'd366, 5'd16, 6'd32, 6'd1, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd2000, 9'd366, 5'd8, 6'd16, 6'd2, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd1, 9'd1, 5'd4, 6'd8, 6'd4, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd9999, 9'd365, 5'd23, 6'd59, 6'd59, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd2024, 9'd59, 5'd2, 6'd4, 6'd8, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd2024, 9'd60, 5'd0, 6'd0, 6'd16, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd2024, 9'd61, 5'd0, 6'd2, 6'd32, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd2023, 9'd59, 5'd0, 6'd0, 6'd0, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd2023, 9'd60, 5'd0, 6'd0, 6'd0, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd2024, 9'd31, 5'd0, 6'd0, 6'd0, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd2024, 9'd32, 5'd0, 6'd0, 6'd0, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd2024, 9'd335, 5'd0, 6'd0, 6'd0, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd1600, 9'd366, 5'd0, 6'd0, 6'd0, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd4, 9'd366, 5'd0, 6'd0, 6'd0, 1'b0, 23'sd0, 17'd0, 1'b0},
    '{14'd9998, 9'd255, 5'd0, 6'd0, 6'd0, 1'b0, 23'sd0, 17'd0, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  utcmjd_in_t  in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  utcmjd_out_t out_data_o;

  utcmjd_out_t pending_mjd [$];
  utcmjd_out_t want_beat;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;

  utc_to_modified_julian_day dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Compute MJD, seconds of day and the date check for one timestamp
  function automatic utcmjd_out_t predict_mjd(input utcmjd_in_t ts);
    utcmjd_out_t r;
    int unsigned yr, doy, leap, month, day, m, secs;
    longint      ys, a, b, c, mjd;
    bit          ok;
    yr   = 32'(ts.year);
    doy  = 32'(ts.day_of_year);
    leap = ((yr % 400) == 0 || ((yr % 100) != 0 && (yr % 4) == 0)) ? 1 : 0;
    ok   = (yr >= 1) && (yr <= LAST_YEAR) && (doy >= 1) && (doy <= 365 + leap);
    mjd  = 0;
    if (ok) begin
      month = 1;
      for (m = 2; m <= 12; m++) begin
        if (doy > MONTH_START_DAY[m] + ((m >= 3) ? leap : 0)) month = m;
      end
      day = doy - MONTH_START_DAY[month] - ((month >= 3) ? leap : 0);
      // January and February count with the previous year
      ys  = longint'(yr) - longint'((12 - month) / 10);
      a   = (1461 * (ys + 4712)) / 4;
      b   = longint'((306 * ((month + 9) % 12) + 5) / 10);
      c   = (3 * ((ys + 4900) / 100)) / 4;
      mjd = a + b - c + longint'(day) - JD_OF_MJD_ZERO;
    end
    secs = 3600 * 32'(ts.hour) + 60 * 32'(ts.minute) + 32'(ts.second);
    r.mjd_day        = mjd[22:0];
    r.seconds_of_day = secs[16:0];
    r.date_valid     = ok;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  // Offer one beat with random idle cycles ahead, queue its result on accept
  task automatic send_beat(input utcmjd_in_t beat, input utcmjd_out_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    pending_mjd.push_back(want);
  endtask

  // Count cycles, stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check each result beat against the oldest pending result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_mjd.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %p", out_data_o));
      end else begin
        want_beat = pending_mjd.pop_front();
        if (out_data_o.mjd_day !== want_beat.mjd_day)
          report_mismatch($sformatf("mjd_day got %0d want %0d",
                                    out_data_o.mjd_day, want_beat.mjd_day));
        if (out_data_o.seconds_of_day !== want_beat.seconds_of_day)
          report_mismatch($sformatf("seconds_of_day got %0d want %0d",
                                    out_data_o.seconds_of_day, want_beat.seconds_of_day));
        if (out_data_o.date_valid !== want_beat.date_valid)
          report_mismatch($sformatf("date_valid got %0b want %0b",
                                    out_data_o.date_valid, want_beat.date_valid));
      end
    end
  end

  // Drive ready: random stalls, plus one long hold-off on request
  initial begin : rx_proc
    int unsigned hold_left;
    bit          hold_started;
    hold_left    = 0;
    hold_started = 1'b0;
    out_ready_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Reset, directed table, random phases, drain
  initial begin : stim_proc
    utcmjd_in_t  ts;
    dir_row_t    row;
    utcmjd_out_t typed_res;
    int unsigned phase, n, kind, leap, mon;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      ts.year        = row.year;
      ts.day_of_year = row.doy;
      ts.hour        = row.hour;
      ts.minute      = row.minute;
      ts.second      = row.second;
      if (row.typed) begin
        typed_res.mjd_day        = row.mjd_day;
        typed_res.seconds_of_day = row.secs;
        typed_res.date_valid     = row.ok;
        send_beat(ts, typed_res);
      end else begin
        send_beat(ts, predict_mjd(ts));
      end
    end

    // Random beats over the idling phases
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (n = 0; n < BEATS_PER_PHASE; n++) begin
        // fill the block while the output holds off
        if (phase == 0 && n == 120) hold_req = 1'b1;
        kind = $urandom_range(99);
        if (kind < 60) begin
          ts.year        = 14'($urandom_range(LAST_YEAR, 1));
          ts.day_of_year = 9'($urandom_range(366, 1));
        end else if (kind < 78) begin
          // near month starts, around leap and century years
          case ($urandom_range(4))
            0: ts.year = 14'd1900;
            1: ts.year = 14'd2000;
            2: ts.year = 14'd2100;
            3: ts.year = 14'(4 * $urandom_range(2499, 1));
            default: ts.year = 14'($urandom_range(LAST_YEAR, 1));
          endcase
          mon  = $urandom_range(12, 1);
          leap = $urandom_range(1);
          ts.day_of_year = 9'(MONTH_START_DAY[mon] + ((mon >= 3) ? leap : 0)
                              + $urandom_range(1, 0));
          if (ts.day_of_year == 9'd0) ts.day_of_year = 9'd1;
        end else if (kind < 92) begin
          ts.year        = 14'($urandom_range(16383));
          ts.day_of_year = 9'($urandom_range(511));
        end else begin
          case ($urandom_range(3))
            0: ts.year = 14'd1;
            1: ts.year = 14'(LAST_YEAR);
            2: ts.year = 14'd0;
            default: ts.year = 14'(LAST_YEAR + 1);
          endcase
          ts.day_of_year = 9'($urandom_range(367));
        end
        if ($urandom_range(99) < 80) begin
          ts.hour   = 5'($urandom_range(23));
          ts.minute = 6'($urandom_range(59));
          ts.second = 6'($urandom_range(60));
        end else begin
          ts.hour   = 5'($urandom_range(31));
          ts.minute = 6'($urandom_range(63));
          ts.second = 6'($urandom_range(63));
        end
        send_beat(ts, predict_mjd(ts));
      end
    end
    in_valid_i <= 1'b0;

    // Let every pending result arrive, then a few more cycles
    while (pending_mjd.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
